// ===== rtl/core/assert_macros.svh =====
// assertion macros shared by the sorted record table rtl
// define NO_ASSERTIONS to compile them out
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef NO_ASSERTIONS

// clocked property, ignored while reset is high
`define SRT_ASSERT(lbl, clk, rst, prop) \
  lbl: assert property (@(posedge clk) disable iff (rst) prop) \
    else $error("sorted record table assertion failed");

// clocked property, checked during reset as well
`define SRT_ASSERT_ALWAYS(lbl, clk, prop) \
  lbl: assert property (@(posedge clk) prop) \
    else $error("sorted record table assertion failed");

`else

`define SRT_ASSERT(lbl, clk, rst, prop)
`define SRT_ASSERT_ALWAYS(lbl, clk, prop)

`endif

`endif

// ===== rtl/core/srt_pkg.sv =====
// types and codes shared by the sorted record table controller and datapath
// no dependencies
package srt_pkg;

  localparam int unsigned KEY_W    = 32;
  localparam int unsigned TYPE_W   = 8;
  localparam int unsigned AMOUNT_W = 32;
  localparam int unsigned POS_W    = 6;

  typedef enum logic [1:0] {
    KIND_INSERT = 2'd0,
    KIND_SEARCH = 2'd1,
    KIND_DELETE = 2'd2,
    KIND_LIST   = 2'd3
  } kind_t;

  typedef enum logic [1:0] {
    ST_OK        = 2'd0,
    ST_NOT_FOUND = 2'd1,
    ST_FULL      = 2'd2,
    ST_EMPTY     = 2'd3
  } status_t;

  typedef struct packed {
    logic [KEY_W-1:0]           key;
    logic [TYPE_W-1:0]          rtype;
    logic signed [AMOUNT_W-1:0] amount;
  } record_t;

  typedef enum logic [2:0] {
    S_IDLE,
    S_DECODE,
    S_INS_CMP,
    S_INS_PUT,
    S_FIND_CMP,
    S_DEL_MOVE,
    S_LIST_EMIT
  } state_t;

  typedef enum logic [2:0] {
    IDX_HOLD,
    IDX_ZERO,
    IDX_COUNT,
    IDX_INC,
    IDX_DEC
  } idx_op_t;

  typedef enum logic [1:0] {
    CNT_HOLD,
    CNT_INC,
    CNT_DEC
  } cnt_op_t;

  typedef enum logic [2:0] {
    RD_ZERO,
    RD_NEXT,
    RD_NEXT2,
    RD_PREV2,
    RD_CNT_M1
  } rd_sel_t;

  typedef enum logic [1:0] {
    SRC_NONE,
    SRC_STORED,
    SRC_NEW
  } emit_src_t;

  typedef struct packed {
    logic      load;
    idx_op_t   idx_op;
    cnt_op_t   cnt_op;
    rd_sel_t   rd_sel;
    logic      wr_en;
    logic      wr_new;
    logic      emit;
    emit_src_t src;
    status_t   status;
    logic      last;
  } dp_cmd_t;

  typedef struct packed {
    kind_t kind;
    logic  cnt_zero;
    logic  cnt_full;
    logic  key_gt;
    logic  key_eq;
    logic  next_end;
    logic  next2_end;
    logic  idx_one;
  } dp_stat_t;

endpackage

// ===== rtl/core/srt_datapath.sv =====
// datapath of the sorted record table: record memory, index and fill count,
// input latch and result registers; depends on srt_pkg and assert_macros.svh
module srt_datapath import srt_pkg::*; #(
  parameter int unsigned CAPACITY = 32
) (
  input  logic                       clk,
  input  logic                       rst,
  input  dp_cmd_t                    cmd,
  output dp_stat_t                   stat,
  input  logic [1:0]                 kind,
  input  logic [KEY_W-1:0]           key,
  input  logic [TYPE_W-1:0]          record_type,
  input  logic signed [AMOUNT_W-1:0] amount,
  output logic                       result_valid,
  output logic [1:0]                 status,
  output logic [POS_W-1:0]           position,
  output logic [KEY_W-1:0]           out_key,
  output logic [TYPE_W-1:0]          out_type,
  output logic signed [AMOUNT_W-1:0] out_amount,
  output logic                       last
);

  localparam int unsigned IDX_W = $clog2(CAPACITY);
  localparam int unsigned CNT_W = $clog2(CAPACITY + 1);
  localparam int unsigned CW    = IDX_W + 2;
  localparam int unsigned PW    = (IDX_W + 1 > POS_W) ? IDX_W + 1 : POS_W;

  record_t            rec_mem [CAPACITY];
  record_t            rdata;
  record_t            new_rec;
  kind_t              kind_r;
  logic [IDX_W-1:0]   idx;
  logic [IDX_W-1:0]   idx_next;
  logic [CNT_W-1:0]   count;
  logic [CNT_W-1:0]   count_next;
  logic [CNT_W-1:0]   cnt_m1;
  logic [IDX_W-1:0]   rd_addr;
  logic [PW-1:0]      pos_wide;

  // input latch
  always_ff @(posedge clk) begin
    if (cmd.load) begin
      kind_r  <= kind_t'(kind);
      new_rec <= '{key: key, rtype: record_type, amount: amount};
    end
  end

  // index and fill count
  always_comb begin
    case (cmd.idx_op)
      IDX_ZERO:  idx_next = '0;
      IDX_COUNT: idx_next = count[IDX_W-1:0];
      IDX_INC:   idx_next = idx + IDX_W'(1);
      IDX_DEC:   idx_next = idx - IDX_W'(1);
      default:   idx_next = idx;
    endcase
  end

  always_comb begin
    case (cmd.cnt_op)
      CNT_INC: count_next = count + CNT_W'(1);
      CNT_DEC: count_next = count - CNT_W'(1);
      default: count_next = count;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      idx   <= '0;
      count <= '0;
    end else begin
      idx   <= idx_next;
      count <= count_next;
    end
  end

  // record memory, one write and one registered read per cycle
  assign cnt_m1 = count - CNT_W'(1);

  always_comb begin
    case (cmd.rd_sel)
      RD_NEXT:   rd_addr = idx + IDX_W'(1);
      RD_NEXT2:  rd_addr = idx + IDX_W'(2);
      RD_PREV2:  rd_addr = idx - IDX_W'(2);
      RD_CNT_M1: rd_addr = cnt_m1[IDX_W-1:0];
      default:   rd_addr = '0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (cmd.wr_en) begin
      rec_mem[idx] <= cmd.wr_new ? new_rec : rdata;
    end
    rdata <= rec_mem[rd_addr];
  end

  // status toward the controller
  assign stat.kind      = kind_r;
  assign stat.cnt_zero  = (count == '0);
  assign stat.cnt_full  = (count == CNT_W'(CAPACITY));
  assign stat.key_gt    = (rdata.key > new_rec.key);
  assign stat.key_eq    = (rdata.key == new_rec.key);
  assign stat.next_end  = (CW'(idx) + CW'(1) == CW'(count));
  assign stat.next2_end = (CW'(idx) + CW'(2) >= CW'(count));
  assign stat.idx_one   = (idx == IDX_W'(1));

  // result registers
  assign pos_wide = PW'(idx) + PW'(1);

  always_ff @(posedge clk) begin
    if (rst) begin
      result_valid <= 1'b0;
    end else begin
      result_valid <= cmd.emit;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.emit) begin
      status <= cmd.status;
      last   <= cmd.last;
      case (cmd.src)
        SRC_STORED: begin
          position   <= pos_wide[POS_W-1:0];
          out_key    <= rdata.key;
          out_type   <= rdata.rtype;
          out_amount <= rdata.amount;
        end
        SRC_NEW: begin
          position   <= pos_wide[POS_W-1:0];
          out_key    <= new_rec.key;
          out_type   <= new_rec.rtype;
          out_amount <= new_rec.amount;
        end
        default: begin
          position   <= '0;
          out_key    <= '0;
          out_type   <= '0;
          out_amount <= '0;
        end
      endcase
    end
  end

  `include "assert_macros.svh"

  `SRT_ASSERT(a_cnt_bound, clk, rst, count <= CNT_W'(CAPACITY))
  `SRT_ASSERT(a_cnt_step, clk, rst, !$stable(count) |-> (count == $past(count) + CNT_W'(1)) || (count == $past(count) - CNT_W'(1)))
  `SRT_ASSERT(a_err_result, clk, rst, (result_valid && status != ST_OK) |-> (last && position == '0))
  `SRT_ASSERT_ALWAYS(a_rst_quiet, clk, rst |=> !result_valid)

endmodule

// ===== rtl/core/srt_ctrl.sv =====
// controller state machine of the sorted record table
// drives datapath commands from its status; depends on srt_pkg and assert_macros.svh
module srt_ctrl import srt_pkg::*; (
  input  logic     clk,
  input  logic     rst,
  input  logic     start,
  output logic     busy,
  input  dp_stat_t stat,
  output dp_cmd_t  cmd
);

  state_t state;
  state_t state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // next state
  always_comb begin
    state_next = state;
    case (state)
      S_IDLE: begin
        if (start) state_next = S_DECODE;
      end
      S_DECODE: begin
        if (stat.kind == KIND_INSERT) begin
          if (stat.cnt_full)      state_next = S_IDLE;
          else if (stat.cnt_zero) state_next = S_INS_PUT;
          else                    state_next = S_INS_CMP;
        end else if (stat.cnt_zero) begin
          state_next = S_IDLE;
        end else if (stat.kind == KIND_LIST) begin
          state_next = S_LIST_EMIT;
        end else begin
          state_next = S_FIND_CMP;
        end
      end
      S_INS_CMP: begin
        if (!stat.key_gt || stat.idx_one) state_next = S_INS_PUT;
      end
      S_INS_PUT: begin
        state_next = S_IDLE;
      end
      S_FIND_CMP: begin
        if (stat.key_eq) begin
          if (stat.kind == KIND_DELETE && !stat.next_end) state_next = S_DEL_MOVE;
          else                                             state_next = S_IDLE;
        end else if (stat.next_end) begin
          state_next = S_IDLE;
        end
      end
      S_DEL_MOVE: begin
        if (stat.next2_end) state_next = S_IDLE;
      end
      S_LIST_EMIT: begin
        if (stat.next_end) state_next = S_IDLE;
      end
      default: state_next = S_IDLE;
    endcase
  end

  // outputs
  always_comb begin
    cmd        = '0;
    cmd.idx_op = IDX_HOLD;
    cmd.cnt_op = CNT_HOLD;
    cmd.rd_sel = RD_ZERO;
    cmd.src    = SRC_NONE;
    cmd.status = ST_OK;
    busy       = (state != S_IDLE);
    case (state)
      S_IDLE: begin
        cmd.load = start;
      end
      S_DECODE: begin
        if (stat.kind == KIND_INSERT) begin
          if (stat.cnt_full) begin
            cmd.emit   = 1'b1;
            cmd.status = ST_FULL;
            cmd.last   = 1'b1;
          end else begin
            cmd.idx_op = IDX_COUNT;
            cmd.rd_sel = RD_CNT_M1;
          end
        end else if (stat.cnt_zero) begin
          cmd.emit   = 1'b1;
          cmd.status = ST_EMPTY;
          cmd.last   = 1'b1;
        end else begin
          cmd.idx_op = IDX_ZERO;
        end
      end
      S_INS_CMP: begin
        // open a slot by moving the larger entry up one place
        if (stat.key_gt) begin
          cmd.wr_en  = 1'b1;
          cmd.idx_op = IDX_DEC;
          cmd.rd_sel = RD_PREV2;
        end
      end
      S_INS_PUT: begin
        cmd.wr_en  = 1'b1;
        cmd.wr_new = 1'b1;
        cmd.cnt_op = CNT_INC;
        cmd.emit   = 1'b1;
        cmd.src    = SRC_NEW;
        cmd.last   = 1'b1;
      end
      S_FIND_CMP: begin
        if (stat.key_eq) begin
          cmd.emit = 1'b1;
          cmd.src  = SRC_STORED;
          cmd.last = 1'b1;
          if (stat.kind == KIND_DELETE) begin
            if (stat.next_end) cmd.cnt_op = CNT_DEC;
            else               cmd.rd_sel = RD_NEXT;
          end
        end else if (stat.next_end) begin
          cmd.emit   = 1'b1;
          cmd.status = ST_NOT_FOUND;
          cmd.last   = 1'b1;
        end else begin
          cmd.idx_op = IDX_INC;
          cmd.rd_sel = RD_NEXT;
        end
      end
      S_DEL_MOVE: begin
        // close the gap by moving the following entry down one place
        cmd.wr_en  = 1'b1;
        cmd.idx_op = IDX_INC;
        if (stat.next2_end) cmd.cnt_op = CNT_DEC;
        else                cmd.rd_sel = RD_NEXT2;
      end
      S_LIST_EMIT: begin
        cmd.emit = 1'b1;
        cmd.src  = SRC_STORED;
        cmd.last = stat.next_end;
        if (!stat.next_end) begin
          cmd.idx_op = IDX_INC;
          cmd.rd_sel = RD_NEXT;
        end
      end
      default: begin
        busy = 1'b1;
      end
    endcase
  end

  `include "assert_macros.svh"

  `SRT_ASSERT(a_accept_busy, clk, rst, (start && !busy) |=> busy)
  `SRT_ASSERT(a_idle_no_update, clk, rst, (state == S_IDLE) |-> (!cmd.wr_en && cmd.cnt_op == CNT_HOLD))
  `SRT_ASSERT(a_put_reports, clk, rst, (cmd.wr_en && cmd.wr_new) |-> (cmd.emit && cmd.src == SRC_NEW))

endmodule

// ===== rtl/core/sorted_record_table.sv =====
// top level of the sorted record table: controller plus datapath
// depends on srt_pkg, srt_ctrl, srt_datapath
//
// Usage:
//   An item (kind, key, record_type, amount) is taken at a rising edge where
//   start is high and busy is low. busy stays high until the item's work ends.
//   Results come out one per cycle on status, position, out_key, out_type,
//   out_amount and last, each marked by result_valid for exactly one cycle;
//   the receiver must take them as they come. last marks an item's final result.
//   Kinds: insert, search, delete, list all. List gives one result per entry.
// Steps of each kind:
//   insert  one compare and shift per cycle from the tail
//   search  one compare per cycle from the head
//   delete  search then one move per cycle down to the tail
//   list    one result per cycle
//   each result is registered before it shows on the ports
//   The record memory, one write port and one registered read port, sets the
//   pace: one entry is read and one written per cycle.
// Reset:
//   rst empties the table and drops result_valid; memory contents are not cleared.
module sorted_record_table import srt_pkg::*; #(
  parameter int unsigned CAPACITY = 32
) (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       start,
  output logic                       busy,
  input  logic [1:0]                 kind,
  input  logic [KEY_W-1:0]           key,
  input  logic [TYPE_W-1:0]          record_type,
  input  logic signed [AMOUNT_W-1:0] amount,
  output logic                       result_valid,
  output logic [1:0]                 status,
  output logic [POS_W-1:0]           position,
  output logic [KEY_W-1:0]           out_key,
  output logic [TYPE_W-1:0]          out_type,
  output logic signed [AMOUNT_W-1:0] out_amount,
  output logic                       last
);

  dp_cmd_t  cmd;
  dp_stat_t stat;

  srt_ctrl u_ctrl (
    .clk   (clk),
    .rst   (rst),
    .start (start),
    .busy  (busy),
    .stat  (stat),
    .cmd   (cmd)
  );

  srt_datapath #(
    .CAPACITY (CAPACITY)
  ) u_datapath (
    .clk          (clk),
    .rst          (rst),
    .cmd          (cmd),
    .stat         (stat),
    .kind         (kind),
    .key          (key),
    .record_type  (record_type),
    .amount       (amount),
    .result_valid (result_valid),
    .status       (status),
    .position     (position),
    .out_key      (out_key),
    .out_type     (out_type),
    .out_amount   (out_amount),
    .last         (last)
  );

endmodule
